// File: sv/sha256_pkg.sv
// SHA-256 stream hasher: shared types, codes and constants.
package sha256_pkg;

	typedef logic [31:0] word_t;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_FINISH  = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [1:0] SRC_DATA = 2'd0;
	localparam logic [1:0] SRC_80   = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_LEN  = 2'd3;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	typedef struct packed {
		logic       push;
		logic [1:0] src;
		logic [2:0] len_idx;
		logic       count;
		logic       restart;
		logic       load_v;
		logic       round_en;
		logic [5:0] round_idx;
		logic       add_hash;
		logic       set_final;
		logic [2:0] out_idx;
		logic       out_zero;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       finalized;
	} status_t;

endpackage

// File: sv/sha256_dp.sv
// SHA-256 datapath: message window, round logic, hash words and counters.
module sha256_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           byte_value,
	input  sha256_pkg::cmd_t     cmd,
	output sha256_pkg::status_t  sts,
	output logic [31:0]          digest_word
);

	sha256_pkg::word_t w_q [16];
	sha256_pkg::word_t v_q [8];
	sha256_pkg::word_t hash_q [8];
	logic [5:0]  fill_q;
	logic [63:0] total_q;
	logic        final_q;

	logic [63:0] bits;
	logic [7:0]  push_byte;
	sha256_pkg::word_t s0, s1, ch, maj, t1, t2, sg0, sg1, w_new;

	function automatic sha256_pkg::word_t ror(input sha256_pkg::word_t x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	assign bits = {total_q[60:0], 3'b000};

	always_comb begin
		case (cmd.src)
			sha256_pkg::SRC_DATA: push_byte = byte_value;
			sha256_pkg::SRC_80:   push_byte = sha256_pkg::PAD_BYTE;
			sha256_pkg::SRC_LEN:  push_byte = 8'(bits >> {~cmd.len_idx, 3'b000});
			default:              push_byte = 8'h00;
		endcase
	end

	always_comb begin
		s1    = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + s1 + ch + sha256_pkg::ROUND_K[cmd.round_idx] + w_q[0];
		s0    = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = s0 + maj;
		sg0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		sg1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + sg0 + w_q[9] + sg1;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			w_q[15] <= {w_q[15][23:0], push_byte};
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_v) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= hash_q[i];
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				hash_q[i] <= sha256_pkg::INIT_H[i];
			fill_q  <= '0;
			total_q <= '0;
			final_q <= 1'b0;
		end else if (cmd.restart) begin
			for (int i = 0; i < 8; i++)
				hash_q[i] <= sha256_pkg::INIT_H[i];
			fill_q  <= '0;
			total_q <= '0;
			final_q <= 1'b0;
		end else begin
			if (cmd.add_hash) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= hash_q[i] + v_q[i];
			end
			if (cmd.push)
				fill_q <= fill_q + 6'd1;
			if (cmd.count)
				total_q <= total_q + 64'd1;
			if (cmd.set_final)
				final_q <= 1'b1;
		end
	end

	assign sts.fill      = fill_q;
	assign sts.finalized = final_q;
	assign digest_word   = cmd.out_zero ? 32'd0 : hash_q[cmd.out_idx];

endmodule

// File: sv/sha256_ctrl.sv
// SHA-256 controller: input decode, padding sequencer, round count and digest output.
module sha256_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 stall,
	input  logic [1:0]           kind,
	output logic                 digest_valid,
	input  logic                 digest_stall,
	output logic [2:0]           word_index,
	output logic                 last_word,
	output sha256_pkg::cmd_t     cmd,
	input  sha256_pkg::status_t  sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_LEN   = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_ADD   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [5:0] rnd_q;
	logic [2:0] len_cnt_q;
	logic [2:0] out_cnt_q;
	logic       fin_q;
	logic       first_q;
	logic       len_done_q;
	logic       zero_q;
	logic       pad_push;

	assign pad_push = first_q || (sts.fill != 6'd56);

	always_comb begin
		cmd           = '0;
		cmd.src       = sha256_pkg::SRC_DATA;
		cmd.len_idx   = len_cnt_q;
		cmd.round_idx = rnd_q;
		cmd.out_idx   = out_cnt_q;
		cmd.out_zero  = zero_q;
		case (state_q)
			ST_IDLE: begin
				if (valid) begin
					case (kind)
						sha256_pkg::KIND_DATA: begin
							cmd.push  = !sts.finalized;
							cmd.count = !sts.finalized;
						end
						sha256_pkg::KIND_RESTART: cmd.restart = 1'b1;
						default: ;
					endcase
				end
			end
			ST_PAD: begin
				cmd.push = pad_push;
				cmd.src  = first_q ? sha256_pkg::SRC_80 : sha256_pkg::SRC_ZERO;
			end
			ST_LEN: begin
				cmd.push = 1'b1;
				cmd.src  = sha256_pkg::SRC_LEN;
			end
			ST_LOAD:  cmd.load_v   = 1'b1;
			ST_ROUND: cmd.round_en = 1'b1;
			ST_ADD: begin
				cmd.add_hash  = 1'b1;
				cmd.set_final = fin_q && len_done_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rnd_q      <= '0;
			len_cnt_q  <= '0;
			out_cnt_q  <= '0;
			fin_q      <= 1'b0;
			first_q    <= 1'b0;
			len_done_q <= 1'b0;
			zero_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (valid) begin
						case (kind)
							sha256_pkg::KIND_DATA: begin
								if (!sts.finalized && sts.fill == 6'd63) begin
									fin_q   <= 1'b0;
									state_q <= ST_LOAD;
								end
							end
							sha256_pkg::KIND_FINISH: begin
								if (sts.finalized) begin
									zero_q    <= 1'b1;
									out_cnt_q <= '0;
									state_q   <= ST_OUT;
								end else begin
									fin_q      <= 1'b1;
									first_q    <= 1'b1;
									len_done_q <= 1'b0;
									state_q    <= ST_PAD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PAD: begin
					if (pad_push) begin
						first_q <= 1'b0;
						if (sts.fill == 6'd63)
							state_q <= ST_LOAD;
					end else begin
						len_cnt_q <= '0;
						state_q   <= ST_LEN;
					end
				end
				ST_LEN: begin
					len_cnt_q <= len_cnt_q + 3'd1;
					if (len_cnt_q == 3'd7) begin
						len_done_q <= 1'b1;
						state_q    <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (len_done_q) begin
						zero_q    <= 1'b0;
						out_cnt_q <= '0;
						state_q   <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!digest_stall) begin
						out_cnt_q <= out_cnt_q + 3'd1;
						if (out_cnt_q == 3'd7) begin
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stall        = (state_q != ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign word_index   = out_cnt_q;
	assign last_word    = (out_cnt_q == 3'd7);

endmodule

// File: sv/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: controller and datapath.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  input    | valid / stall               | kind, byte_value
//  digest   | digest_valid / digest_stall | digest_word, word_index, last_word
//
// A data byte is pushed as it is accepted; the byte that fills a 64-byte block then adds
// a block hash (load, 64 rounds at one round per cycle, hash update).
// Finish: the accept, then pad or length bytes up to the block end plus a turn step with
// no push before the length bytes, a block hash as above per block hashed (one or two),
// then eight digest transfers. Finish when already finalized
// goes straight to the eight transfers, with every digest word zero.
// stall is high whenever the block is busy; digest_stall only holds the current word.
// arst_n loads the initial hash words and clears the counters and state.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  byte_value,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha256_pkg::cmd_t    cmd;
	sha256_pkg::status_t sts;

	sha256_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid),
		.stall        (stall),
		.kind         (kind),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.word_index   (word_index),
		.last_word    (last_word),
		.cmd          (cmd),
		.sts          (sts)
	);

	sha256_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_value  (byte_value),
		.cmd         (cmd),
		.sts         (sts),
		.digest_word (digest_word)
	);

endmodule
